[rtl/rau_pkg.sv]
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int WORD_BITS  = 64;
  localparam int FIELD_BITS = 64;
  localparam int OP_BITS    = 4;
  localparam int SHIFT_BITS = 6;
  localparam int IN_BITS    = 264;
  localparam int OUT_BITS   = 136;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_NEG  = 4'd4,
    OP_POW2 = 4'd5,
    OP_EQ   = 4'd6,
    OP_LT   = 4'd7,
    OP_LE   = 4'd8,
    OP_GT   = 4'd9,
    OP_GE   = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    CMD_MUL = 2'd0,
    CMD_DIV = 2'd1,
    CMD_GCD = 2'd2
  } eng_cmd_t;

  typedef struct packed {
    logic     start;
    eng_cmd_t cmd;
  } eng_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_RED_GCD,
    S_RED_DIVN,
    S_RED_DIVD,
    S_RET_B,
    S_ADD_CD,
    S_ADD_XN,
    S_ADD_YN,
    S_ADD_SUM,
    S_MUL_N,
    S_MUL_D,
    S_CMP_G,
    S_CMP_Q,
    S_CMP_LC,
    S_CMP_QA,
    S_CMP_L,
    S_CMP_QB,
    S_CMP_R,
    S_CMP_EVAL,
    S_FINAL,
    S_DONE
  } state_t;

endpackage

[rtl/rational_arithmetic_unit_core.sv]
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core
// Sign-magnitude rational ALU; every produced fraction is gcd reduced.
// ----------------------------------------------------------------------------
// engine calls: neg and pow2 run one gcd and two divides, sub two gcds and
//   seven multiplies/divides, div two gcds and six, compares one gcd and six
// throughput: one request at a time; a new request is taken while the last
//   result still waits in the output register
// reset: rst clears the sequencer, the engine and the output valid
module rational_arithmetic_unit_core #(
  parameter int WORD_BITS = rau_pkg::WORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // a_sign, a_numerator, a_denominator, b_sign, b_numerator, b_denominator,
  // shift_amount
  input  logic [rau_pkg::IN_BITS-1:0]  s_tdata,
  // op
  input  logic [rau_pkg::OP_BITS-1:0]  s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // res_sign, res_numerator, res_denominator, zero pad
  output logic [rau_pkg::OUT_BITS-1:0] m_tdata,
  // compare_true, zero_denominator
  output logic [1:0]                   m_tuser
);

  localparam int FB = rau_pkg::FIELD_BITS;

  rau_pkg::state_t state, state_next;
  logic            issued;
  logic            red_to_b;

  logic [3:0]                     op;
  logic                           sa, sb;
  logic [WORD_BITS-1:0]           an, ad, bn, bd;
  logic [rau_pkg::SHIFT_BITS-1:0] sh;
  logic                           rs;
  logic [WORD_BITS-1:0]           rn, rd;
  logic [WORD_BITS-1:0]           t0, t1, t2;
  logic                           cmp, flag;

  logic                 o_sign, o_cmp, o_flag;
  logic [WORD_BITS-1:0] o_num, o_den;

  rau_pkg::eng_req_t    req;
  logic [WORD_BITS-1:0] ep, eq_op;
  logic                 e_done;
  logic [WORD_BITS-1:0] e_res;
  logic                 call;

  logic eq_ab, lt_ab, lt_ba, cmp_val;
  logic add_gt;

  rau_engine #(.WORD_BITS(WORD_BITS)) u_engine (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .p      (ep),
    .q      (eq_op),
    .done   (e_done),
    .result (e_res)
  );

  assign s_tready = state == rau_pkg::S_IDLE;
  assign m_tdata  = {{(rau_pkg::OUT_BITS - 2 * FB - 1){1'b0}},
                     FB'(o_den), FB'(o_num), o_sign};
  assign m_tuser  = {o_flag, o_cmp};

  // engine operand and command select for each call step
  always_comb begin
    call  = 1'b1;
    req   = '{start: 1'b0, cmd: rau_pkg::CMD_MUL};
    ep    = an;
    eq_op = bn;
    unique case (state)
      rau_pkg::S_RED_GCD:  begin req.cmd = rau_pkg::CMD_GCD; ep = rn; eq_op = rd; end
      rau_pkg::S_RED_DIVN: begin req.cmd = rau_pkg::CMD_DIV; ep = rn; eq_op = t0; end
      rau_pkg::S_RED_DIVD: begin req.cmd = rau_pkg::CMD_DIV; ep = rd; eq_op = t0; end
      rau_pkg::S_ADD_CD:   begin ep = ad; eq_op = bd; end
      rau_pkg::S_ADD_XN:   begin ep = an; eq_op = bd; end
      rau_pkg::S_ADD_YN:   begin ep = bn; eq_op = ad; end
      rau_pkg::S_MUL_N:    begin ep = an; eq_op = bn; end
      rau_pkg::S_MUL_D:    begin ep = ad; eq_op = bd; end
      rau_pkg::S_CMP_G:    begin req.cmd = rau_pkg::CMD_GCD; ep = ad; eq_op = bd; end
      rau_pkg::S_CMP_Q:    begin req.cmd = rau_pkg::CMD_DIV; ep = ad; eq_op = t0; end
      rau_pkg::S_CMP_LC:   begin ep = t0; eq_op = bd; end
      rau_pkg::S_CMP_QA:   begin req.cmd = rau_pkg::CMD_DIV; ep = t0; eq_op = ad; end
      rau_pkg::S_CMP_L:    begin ep = an; eq_op = t1; end
      rau_pkg::S_CMP_QB:   begin req.cmd = rau_pkg::CMD_DIV; ep = t0; eq_op = bd; end
      rau_pkg::S_CMP_R:    begin ep = bn; eq_op = t2; end
      default:             call = 1'b0;
    endcase
    req.start = call && !issued;
  end

  always_comb begin
    eq_ab  = (sa == sb) && (t1 == t2);
    lt_ab  = (sa && !sb) || ((sa == sb) && (sa ? (t2 < t1) : (t1 < t2)));
    lt_ba  = (sb && !sa) || ((sa == sb) && (sb ? (t1 < t2) : (t2 < t1)));
    add_gt = t1 > t2;
    unique case (op)
      rau_pkg::OP_EQ: cmp_val = eq_ab;
      rau_pkg::OP_LT: cmp_val = lt_ab;
      rau_pkg::OP_LE: cmp_val = eq_ab || lt_ab;
      rau_pkg::OP_GT: cmp_val = lt_ba;
      rau_pkg::OP_GE: cmp_val = eq_ab || lt_ba;
      default:        cmp_val = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rau_pkg::S_IDLE:     if (s_tvalid) state_next = rau_pkg::S_DISPATCH;
      rau_pkg::S_DISPATCH: begin
        unique case (op)
          rau_pkg::OP_ADD: state_next = rau_pkg::S_ADD_CD;
          rau_pkg::OP_MUL: state_next = rau_pkg::S_MUL_N;
          rau_pkg::OP_SUB, rau_pkg::OP_DIV, rau_pkg::OP_NEG, rau_pkg::OP_POW2:
            state_next = rau_pkg::S_RED_GCD;
          rau_pkg::OP_EQ, rau_pkg::OP_LT, rau_pkg::OP_LE, rau_pkg::OP_GT,
          rau_pkg::OP_GE:
            state_next = (ad == '0 || bd == '0) ? rau_pkg::S_DONE : rau_pkg::S_CMP_G;
          default: state_next = rau_pkg::S_DONE;
        endcase
      end
      rau_pkg::S_RED_GCD: if (e_done) begin
        if (e_res == '0) state_next = red_to_b ? rau_pkg::S_RET_B : rau_pkg::S_FINAL;
        else             state_next = rau_pkg::S_RED_DIVN;
      end
      rau_pkg::S_RED_DIVN: if (e_done) state_next = rau_pkg::S_RED_DIVD;
      rau_pkg::S_RED_DIVD: if (e_done) begin
        state_next = red_to_b ? rau_pkg::S_RET_B : rau_pkg::S_FINAL;
      end
      rau_pkg::S_RET_B:
        state_next = (op == rau_pkg::OP_SUB) ? rau_pkg::S_ADD_CD : rau_pkg::S_MUL_N;
      rau_pkg::S_ADD_CD:   if (e_done) state_next = rau_pkg::S_ADD_XN;
      rau_pkg::S_ADD_XN:   if (e_done) state_next = rau_pkg::S_ADD_YN;
      rau_pkg::S_ADD_YN:   if (e_done) state_next = rau_pkg::S_ADD_SUM;
      rau_pkg::S_ADD_SUM:  state_next = rau_pkg::S_RED_GCD;
      rau_pkg::S_MUL_N:    if (e_done) state_next = rau_pkg::S_MUL_D;
      rau_pkg::S_MUL_D:    if (e_done) state_next = rau_pkg::S_RED_GCD;
      rau_pkg::S_CMP_G:    if (e_done) state_next = rau_pkg::S_CMP_Q;
      rau_pkg::S_CMP_Q:    if (e_done) state_next = rau_pkg::S_CMP_LC;
      rau_pkg::S_CMP_LC:   if (e_done) state_next = rau_pkg::S_CMP_QA;
      rau_pkg::S_CMP_QA:   if (e_done) state_next = rau_pkg::S_CMP_L;
      rau_pkg::S_CMP_L:    if (e_done) state_next = rau_pkg::S_CMP_QB;
      rau_pkg::S_CMP_QB:   if (e_done) state_next = rau_pkg::S_CMP_R;
      rau_pkg::S_CMP_R:    if (e_done) state_next = rau_pkg::S_CMP_EVAL;
      rau_pkg::S_CMP_EVAL: state_next = rau_pkg::S_DONE;
      rau_pkg::S_FINAL:    state_next = rau_pkg::S_DONE;
      rau_pkg::S_DONE:     if (!m_tvalid || m_tready) state_next = rau_pkg::S_IDLE;
      default:             state_next = rau_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rau_pkg::S_IDLE;
      issued   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (req.start) issued <= 1'b1;
      if (e_done)    issued <= 1'b0;
      if (m_tready)  m_tvalid <= 1'b0;

      unique case (state)
        rau_pkg::S_IDLE: if (s_tvalid) begin
          op <= s_tuser;
          sa <= s_tdata[0];
          an <= WORD_BITS'(s_tdata[FB:1]);
          ad <= WORD_BITS'(s_tdata[2*FB:FB+1]);
          sb <= s_tdata[2*FB+1];
          bn <= WORD_BITS'(s_tdata[3*FB+1:2*FB+2]);
          bd <= WORD_BITS'(s_tdata[4*FB+1:3*FB+2]);
          sh <= s_tdata[4*FB+rau_pkg::SHIFT_BITS+1:4*FB+2];
        end
        rau_pkg::S_DISPATCH: begin
          rs       <= 1'b0;
          rn       <= '0;
          rd       <= '0;
          cmp      <= 1'b0;
          flag     <= 1'b0;
          red_to_b <= 1'b0;
          unique case (op)
            rau_pkg::OP_SUB: begin
              rs <= ~sb; rn <= bn; rd <= bd; red_to_b <= 1'b1;
            end
            rau_pkg::OP_DIV: begin
              rs <= sb; rn <= bd; rd <= bn; red_to_b <= 1'b1;
            end
            rau_pkg::OP_NEG:  begin rs <= ~sa; rn <= an; rd <= ad; end
            rau_pkg::OP_POW2: begin rs <= sa; rn <= an << sh; rd <= ad; end
            rau_pkg::OP_EQ, rau_pkg::OP_LT, rau_pkg::OP_LE, rau_pkg::OP_GT,
            rau_pkg::OP_GE:
              if (ad == '0 || bd == '0) flag <= 1'b1;
            default: ;
          endcase
        end
        rau_pkg::S_RED_GCD: if (e_done) begin
          t0 <= e_res;
          // 0/0 reduces to 0/0 and raises the flag
          if (e_res == '0) begin
            flag <= 1'b1;
            rn   <= '0;
            rd   <= '0;
          end
        end
        rau_pkg::S_RED_DIVN: if (e_done) rn <= e_res;
        rau_pkg::S_RED_DIVD: if (e_done) rd <= e_res;
        rau_pkg::S_RET_B: begin
          sb       <= rs;
          bn       <= rn;
          bd       <= rd;
          red_to_b <= 1'b0;
        end
        rau_pkg::S_ADD_CD: if (e_done) rd <= e_res;
        rau_pkg::S_ADD_XN: if (e_done) t1 <= e_res;
        rau_pkg::S_ADD_YN: if (e_done) t2 <= e_res;
        rau_pkg::S_ADD_SUM: begin
          priority if (sa == sb) begin
            rs <= sa; rn <= t1 + t2;
          end else if (add_gt) begin
            rs <= sa; rn <= t1 - t2;
          end else begin
            rs <= sb; rn <= t2 - t1;
          end
        end
        rau_pkg::S_MUL_N: if (e_done) begin rs <= sa ^ sb; rn <= e_res; end
        rau_pkg::S_MUL_D: if (e_done) rd <= e_res;
        rau_pkg::S_CMP_G, rau_pkg::S_CMP_Q, rau_pkg::S_CMP_LC:
          if (e_done) t0 <= e_res;
        rau_pkg::S_CMP_QA, rau_pkg::S_CMP_L: if (e_done) t1 <= e_res;
        rau_pkg::S_CMP_QB, rau_pkg::S_CMP_R: if (e_done) t2 <= e_res;
        rau_pkg::S_CMP_EVAL: cmp <= cmp_val;
        rau_pkg::S_FINAL: if (rd == '0) flag <= 1'b1;
        rau_pkg::S_DONE: if (!m_tvalid || m_tready) begin
          o_sign   <= rs;
          o_num    <= rn;
          o_den    <= rd;
          o_cmp    <= cmp;
          o_flag   <= flag;
          m_tvalid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/rau_engine.sv]
// ----------------------------------------------------------------------------
// rau_engine
// Shared iterative unit: shift-add multiply (low word), restoring divide and
// binary gcd, one bit or one step per cycle.
// ----------------------------------------------------------------------------
module rau_engine #(
  parameter int WORD_BITS = rau_pkg::WORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rau_pkg::eng_req_t     req,
  input  logic [WORD_BITS-1:0]  p,
  input  logic [WORD_BITS-1:0]  q,
  output logic                  done,
  output logic [WORD_BITS-1:0]  result
);

  localparam int CW = $clog2(WORD_BITS);

  logic                 busy;
  rau_pkg::eng_cmd_t    cmd_r;
  logic [WORD_BITS-1:0] x;
  logic [WORD_BITS-1:0] y;
  logic [WORD_BITS-1:0] acc;
  logic [WORD_BITS-1:0] rem;
  logic [CW-1:0]        cnt;
  logic [CW-1:0]        k;

  logic [WORD_BITS-1:0] mul_sum;
  logic [WORD_BITS:0]   rem_sh;
  logic                 div_ge;
  logic [WORD_BITS:0]   rem_sub;
  logic                 last;

  always_comb begin
    mul_sum = acc + (y[0] ? x : '0);
    rem_sh  = {rem, x[WORD_BITS-1]};
    div_ge  = rem_sh >= {1'b0, y};
    rem_sub = rem_sh - {1'b0, y};
    last    = cnt == CW'(WORD_BITS - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        cmd_r <= req.cmd;
        x     <= p;
        y     <= q;
        acc   <= '0;
        rem   <= '0;
        cnt   <= '0;
        k     <= '0;
      end else if (busy) begin
        unique case (cmd_r)
          rau_pkg::CMD_MUL: begin
            acc <= mul_sum;
            x   <= x << 1;
            y   <= y >> 1;
            cnt <= cnt + 1'b1;
            if (last) begin
              busy   <= 1'b0;
              done   <= 1'b1;
              result <= mul_sum;
            end
          end
          rau_pkg::CMD_DIV: begin
            // y holds the divisor, x shifts out dividend and in quotient
            rem <= div_ge ? rem_sub[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
            x   <= {x[WORD_BITS-2:0], div_ge};
            cnt <= cnt + 1'b1;
            if (last) begin
              busy   <= 1'b0;
              done   <= 1'b1;
              result <= {x[WORD_BITS-2:0], div_ge};
            end
          end
          rau_pkg::CMD_GCD: begin
            priority if (y == '0) begin
              busy   <= 1'b0;
              done   <= 1'b1;
              result <= x << k;
            end else if (x == '0) begin
              busy   <= 1'b0;
              done   <= 1'b1;
              result <= y << k;
            end else if (!x[0] && !y[0]) begin
              x <= x >> 1;
              y <= y >> 1;
              k <= k + 1'b1;
            end else if (!x[0]) begin
              x <= x >> 1;
            end else if (!y[0]) begin
              y <= y >> 1;
            end else if (x >= y) begin
              x <= x - y;
            end else begin
              y <= y - x;
            end
          end
          default: begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        endcase
      end
    end
  end

endmodule
